/* hw/rtl/ldts_pkg.sv */
// Shared types and constants for the two-wire LED driver serializer.
// No dependencies; imported by ldts_seq and the core top level.
`default_nettype none

package ldts_pkg;

    localparam int NUM_DIGITS    = 4;
    localparam int NUM_IN_DIGITS = 4;
    localparam int FRAME_DEPTH   = 7;
    localparam int IDX_W         = $clog2(FRAME_DEPTH);

    localparam logic [7:0] DATA_CMD  = 8'h40;
    localparam logic [7:0] ADDR_CMD  = 8'hC0;
    localparam logic [7:0] CTRL_BASE = 8'h84;

    localparam logic [3:0] BRIGHTNESS_RESET = 4'd4;
    localparam logic [3:0] FRAME_LEN_SHORT  = 4'd1;
    localparam logic [3:0] FRAME_LEN_DIGITS = 4'(1 + NUM_DIGITS);

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SHOW = 2'd1,
        CMD_INIT = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        SEG_IDLE  = 3'd0,
        SEG_START = 3'd1,
        SEG_BIT   = 3'd2,
        SEG_ACK   = 3'd3,
        SEG_STOP  = 3'd4
    } t_seg;

    typedef enum logic [1:0] {
        FRAME_CTRL  = 2'd0,
        FRAME_DATA  = 2'd1,
        FRAME_DISP  = 2'd2
    } t_frame;

    typedef logic [NUM_IN_DIGITS-1:0][7:0] t_digits;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/ldts_seq.sv */
// Pin-step sequencer: frame state, latched frame bytes and per-request result.
// Depends on ldts_pkg.
`default_nettype none

module ldts_seq
    import ldts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [1:0] i_cmd,
    input  wire t_digits    i_digits,
    input  wire logic [3:0] i_brightness,
    output t_result         o_result
);

    t_seg             r_seg, n_seg;
    logic [1:0]       r_step, n_step;
    logic [3:0]       r_bit_count, n_bit_count;
    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]       r_shift_byte, n_shift_byte;
    logic             r_clk_pin, n_clk_pin;
    logic             r_dio_pin, n_dio_pin;
    t_frame           r_frame_no, n_frame_no;

    logic [7:0]       r_frame_bytes [FRAME_DEPTH];
    logic [7:0]       n_frame_bytes [FRAME_DEPTH];

    logic             w_busy;
    logic             w_arm;
    logic             w_done;
    logic             w_rej;
    logic [IDX_W-1:0] w_idx_next;
    logic [IDX_W-1:0] w_idx;
    logic [3:0]       w_frame_len;
    logic [7:0]       w_cur_byte;

    assign w_busy     = (r_seg != SEG_IDLE);
    assign w_idx_next = IDX_W'(r_byte_index + 1'b1);
    assign w_idx      = (r_seg == SEG_ACK) ? w_idx_next : r_byte_index;
    assign w_frame_len = (r_frame_no == FRAME_DISP) ? FRAME_LEN_DIGITS : FRAME_LEN_SHORT;

    always_comb begin
        case (r_frame_no)
            FRAME_CTRL: w_cur_byte = 8'(CTRL_BASE + {4'd0, i_brightness});
            FRAME_DATA: w_cur_byte = DATA_CMD;
            default: begin
                if (32'(w_idx) < FRAME_DEPTH) begin
                    w_cur_byte = r_frame_bytes[w_idx];
                end else begin
                    w_cur_byte = 8'h00;
                end
            end
        endcase
    end

    // new frame bytes for an accepted show or init
    always_comb begin
        for (int i = 0; i < FRAME_DEPTH; i++) begin
            n_frame_bytes[i] = 8'h00;
        end
        n_frame_bytes[0] = ADDR_CMD;
        for (int d = 0; d < NUM_IN_DIGITS; d++) begin
            if (i_cmd == CMD_SHOW) begin
                n_frame_bytes[d+1] = i_digits[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg        <= SEG_IDLE;
            r_step       <= 2'd0;
            r_bit_count  <= 4'd0;
            r_byte_index <= '0;
            r_shift_byte <= 8'h00;
            r_clk_pin    <= 1'b1;
            r_dio_pin    <= 1'b1;
            r_frame_no   <= FRAME_CTRL;
        end else begin
            r_seg        <= n_seg;
            r_step       <= n_step;
            r_bit_count  <= n_bit_count;
            r_byte_index <= n_byte_index;
            r_shift_byte <= n_shift_byte;
            r_clk_pin    <= n_clk_pin;
            r_dio_pin    <= n_dio_pin;
            r_frame_no   <= n_frame_no;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_arm) begin
            r_frame_bytes <= n_frame_bytes;
        end
    end

    always_comb begin
        n_seg        = r_seg;
        n_step       = r_step;
        n_bit_count  = r_bit_count;
        n_byte_index = r_byte_index;
        n_shift_byte = r_shift_byte;
        n_clk_pin    = r_clk_pin;
        n_dio_pin    = r_dio_pin;
        n_frame_no   = r_frame_no;
        w_arm        = 1'b0;
        w_done       = 1'b0;
        w_rej        = 1'b0;

        if (i_fire) begin
            case (i_cmd)
                CMD_TICK: begin
                    case (r_seg)
                        SEG_START: begin
                            if (r_step == 2'd0) begin
                                n_clk_pin = 1'b1;
                                n_dio_pin = 1'b1;
                                n_step    = 2'd1;
                            end else begin
                                n_dio_pin    = 1'b0;
                                n_shift_byte = w_cur_byte;
                                n_bit_count  = 4'd0;
                                n_seg        = SEG_BIT;
                                n_step       = 2'd0;
                            end
                        end
                        SEG_BIT: begin
                            if (r_step == 2'd0) begin
                                n_clk_pin = 1'b0;
                                n_dio_pin = r_shift_byte[0];
                                n_step    = 2'd1;
                            end else begin
                                n_clk_pin    = 1'b1;
                                n_shift_byte = r_shift_byte >> 1;
                                n_bit_count  = 4'(r_bit_count + 4'd1);
                                n_step       = 2'd0;
                                if (r_bit_count == 4'd7) begin
                                    n_seg = SEG_ACK;
                                end
                            end
                        end
                        SEG_ACK: begin
                            if (r_step == 2'd0) begin
                                n_clk_pin = 1'b0;
                                n_step    = 2'd1;
                            end else if (r_step == 2'd1) begin
                                n_clk_pin = 1'b1;
                                n_step    = 2'd2;
                            end else begin
                                n_clk_pin    = 1'b0;
                                n_byte_index = w_idx_next;
                                if ({1'b0, w_idx_next} < w_frame_len) begin
                                    n_shift_byte = w_cur_byte;
                                    n_bit_count  = 4'd0;
                                    n_seg        = SEG_BIT;
                                    n_step       = 2'd0;
                                end else begin
                                    n_seg  = SEG_STOP;
                                    n_step = 2'd0;
                                end
                            end
                        end
                        SEG_STOP: begin
                            if (r_step == 2'd0) begin
                                n_clk_pin = 1'b0;
                                n_dio_pin = 1'b0;
                                n_step    = 2'd1;
                            end else if (r_step == 2'd1) begin
                                n_clk_pin = 1'b1;
                                n_step    = 2'd2;
                            end else begin
                                n_dio_pin    = 1'b1;
                                n_step       = 2'd0;
                                n_byte_index = '0;
                                if (r_frame_no == FRAME_CTRL) begin
                                    n_frame_no = FRAME_DATA;
                                    n_seg      = SEG_START;
                                end else if (r_frame_no == FRAME_DATA) begin
                                    n_frame_no = FRAME_DISP;
                                    n_seg      = SEG_START;
                                end else begin
                                    n_seg  = SEG_IDLE;
                                    w_done = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_seg = SEG_IDLE;
                        end
                    endcase
                end
                CMD_SHOW, CMD_INIT: begin
                    if (w_busy) begin
                        w_rej = 1'b1;
                    end else begin
                        w_arm        = 1'b1;
                        n_frame_no   = (i_cmd == CMD_SHOW) ? FRAME_DATA : FRAME_CTRL;
                        n_byte_index = '0;
                        n_bit_count  = 4'd0;
                        n_seg        = SEG_START;
                        n_step       = 2'd0;
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.clk_level  = n_clk_pin;
        o_result.dio_level  = n_dio_pin;
        o_result.busy_res   = (n_seg != SEG_IDLE);
        o_result.frame_done = w_done;
        o_result.rejected   = w_rej;
    end

endmodule

`default_nettype wire

/* hw/rtl/led_driver_two_wire_serializer_core.sv */
// Top level of the two-wire LED driver serializer: request and result
// registers, brightness register. Depends on ldts_pkg and ldts_seq.
//
// Usage:
//   Requests enter on i_valid/o_ready with i_cmd and i_digit0..3. A tick
//   request advances the clock/data pins by one step; show and init arm a
//   frame sequence. Each request yields exactly one result on
//   o_valid/i_ready carrying the pin levels, busy, frame-done and rejected.
//   Brightness is written through i_cfg_we/i_brightness by the user, only while
//   idle; the block itself does not enforce this.
// Timing:
//   An accepted request waits in the request register and is processed once
//   the result register is free or read; sequencer state and result register
//   update together, and the result is offered from then on. One request per
//   cycle is sustained while i_ready stays high.
//
// Reset (synchronous, active low): pins idle high, sequencer idle,
// brightness 4, both registers empty.
// Receiver stall: the held result blocks processing; the request register
// still takes one more request, after which o_ready drops.
`default_nettype none

module led_driver_two_wire_serializer_core
    import ldts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_digit0,
    input  wire logic [7:0] i_digit1,
    input  wire logic [7:0] i_digit2,
    input  wire logic [7:0] i_digit3,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_brightness,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_clk_level,
    output logic            o_dio_level,
    output logic            o_busy_res,
    output logic            o_frame_done,
    output logic            o_rejected
);

    logic       r_in_valid;
    logic [1:0] r_in_cmd;
    t_digits    r_in_digits;
    logic       r_out_valid;
    t_result    r_out;
    logic [3:0] r_brightness;

    logic       w_proc;
    t_result    w_result;

    assign w_proc  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHTNESS_RESET;
        end else if (i_cfg_we) begin
            r_brightness <= i_brightness;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd    <= i_cmd;
            r_in_digits <= {i_digit3, i_digit2, i_digit1, i_digit0};
        end
    end

    ldts_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_proc),
        .i_cmd        (r_in_cmd),
        .i_digits     (r_in_digits),
        .i_brightness (r_brightness),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_clk_level  = r_out.clk_level;
    assign o_dio_level  = r_out.dio_level;
    assign o_busy_res   = r_out.busy_res;
    assign o_frame_done = r_out.frame_done;
    assign o_rejected   = r_out.rejected;

endmodule

`default_nettype wire
